FILE: hw/rtl/stl_pkg.sv
// Shared types, token codes and decode functions for the script token lexer.
`default_nettype none

package stl_pkg;

    localparam int MAX_NAME_CHARS_DEF = 16;
    localparam int MAX_DEC_DIGITS_DEF = 7;
    localparam int MAX_HEX_DIGITS_DEF = 4;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef logic [5:0] kind_t;

    localparam kind_t K_ERROR   = 6'd0;
    localparam kind_t K_END     = 6'd1;
    localparam kind_t K_NEWLINE = 6'd2;
    localparam kind_t K_SPACE   = 6'd3;
    localparam kind_t K_QUOTE   = 6'd4;
    localparam kind_t K_PLUS    = 6'd5;
    localparam kind_t K_MINUS   = 6'd6;
    localparam kind_t K_COMMENT = 6'd7;
    localparam kind_t K_MUL     = 6'd8;
    localparam kind_t K_DIV     = 6'd9;
    localparam kind_t K_MOD     = 6'd10;
    localparam kind_t K_LT      = 6'd11;
    localparam kind_t K_LE      = 6'd12;
    localparam kind_t K_SHL     = 6'd13;
    localparam kind_t K_GT      = 6'd14;
    localparam kind_t K_GE      = 6'd15;
    localparam kind_t K_SHR     = 6'd16;
    localparam kind_t K_ASSIGN  = 6'd17;
    localparam kind_t K_EQ      = 6'd18;
    localparam kind_t K_BNOT    = 6'd19;
    localparam kind_t K_NE      = 6'd20;
    localparam kind_t K_AND     = 6'd21;
    localparam kind_t K_BAND    = 6'd22;
    localparam kind_t K_OR      = 6'd23;
    localparam kind_t K_BOR     = 6'd24;
    localparam kind_t K_XOR     = 6'd25;
    localparam kind_t K_COMMA   = 6'd26;
    localparam kind_t K_LPAR    = 6'd27;
    localparam kind_t K_RPAR    = 6'd28;
    localparam kind_t K_LBRACE  = 6'd29;
    localparam kind_t K_RBRACE  = 6'd30;
    localparam kind_t K_LBRACK  = 6'd31;
    localparam kind_t K_RBRACK  = 6'd32;
    localparam kind_t K_NUMBER  = 6'd33;
    localparam kind_t K_NAME    = 6'd34;
    localparam kind_t K_CHAR    = 6'd35;
    localparam kind_t K_KW_BASE = 6'd36;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_STRING,
        MODE_COMMENT
    } mode_t;

    typedef enum logic [2:0] {
        PK_NONE,
        PK_NUM,
        PK_NAME,
        PK_OP,
        PK_ESC,
        PK_HEX
    } pend_t;

    typedef struct packed {
        kind_t        kind;
        logic [7:0]   ch;
        logic [15:0]  num;
        logic [4:0]   len;
        logic [63:0]  lo;
        logic [63:0]  hi;
        logic [15:0]  line;
        logic [1:0]   err;
        logic         last;
    } res_t;

    typedef struct packed {
        logic [1:0] cnt;
        res_t       d0;
        res_t       d1;
    } push_t;

    localparam logic [63:0] KW_WORD [15] = '{
        64'h00006e6f69746361, 64'h0000006b61657262, 64'h65756e69746e6f63,
        64'h0000006b636f6c62, 64'h0000000065736c65, 64'h0000666965736c65,
        64'h0000000000646e65, 64'h00000065736c6166, 64'h0000000000726f66,
        64'h6e6f6974636e7566, 64'h0000000000006669, 64'h00006e7275746572,
        64'h0000000065757274, 64'h0000000000726176, 64'h000000656c696877
    };
    localparam logic [4:0] KW_LEN [15] = '{
        5'd6, 5'd5, 5'd8, 5'd5, 5'd4, 5'd6, 5'd3, 5'd5, 5'd3, 5'd8, 5'd2, 5'd6,
        5'd4, 5'd3, 5'd5
    };

    function automatic kind_t kw_kind(input logic [63:0] lo, input logic [4:0] len);
        kind_t k;
        k = K_NAME;
        for (int i = 14; i >= 0; i--) begin
            if (len == KW_LEN[i] && lo == KW_WORD[i]) begin
                k = K_KW_BASE + kind_t'(i);
            end
        end
        return k;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
    endfunction

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd0;
        if (c >= "0" && c <= "9") begin
            t = c - "0";
            return {1'b1, t[3:0]};
        end else if (c >= "a" && c <= "f") begin
            t = c - "a" + 8'd10;
            return {1'b1, t[3:0]};
        end else if (c >= "A" && c <= "F") begin
            t = c - "A" + 8'd10;
            return {1'b1, t[3:0]};
        end
        return 5'd0;
    endfunction

    function automatic kind_t op_single(input logic [7:0] f);
        case (f)
            "-": return K_MINUS;
            "<": return K_LT;
            ">": return K_GT;
            "=": return K_ASSIGN;
            "!": return K_BNOT;
            "&": return K_BAND;
            default: return K_BOR;
        endcase
    endfunction

    // K_ERROR means the two bytes do not form an operator
    function automatic kind_t op_pair(input logic [7:0] f, input logic [7:0] b);
        if (f == "-" && b == "-") return K_COMMENT;
        if (f == "<" && b == "=") return K_LE;
        if (f == "<" && b == "<") return K_SHL;
        if (f == ">" && b == "=") return K_GE;
        if (f == ">" && b == ">") return K_SHR;
        if (f == "=" && b == "=") return K_EQ;
        if (f == "!" && b == "=") return K_NE;
        if (f == "&" && b == "&") return K_AND;
        if (f == "|" && b == "|") return K_OR;
        return K_ERROR;
    endfunction

    function automatic logic [7:0] esc_map(input logic [7:0] b);
        case (b)
            "a": return 8'd7;
            "b": return 8'd8;
            "f": return 8'd12;
            "n": return 8'd10;
            "r": return 8'd13;
            "t": return 8'd9;
            "v": return 8'd11;
            "\\": return "\\";
            "'": return "'";
            "\"": return "\"";
            "?": return "?";
            8'd13, 8'd10: return " ";
            default: return "\\";
        endcase
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/stl_front.sv
// Front end: lexer state and byte classification, up to two results per item.
`default_nettype none

module stl_front import stl_pkg::*; #(
    parameter int MAX_NAME_CHARS = MAX_NAME_CHARS_DEF,
    parameter int MAX_DEC_DIGITS = MAX_DEC_DIGITS_DEF,
    parameter int MAX_HEX_DIGITS = MAX_HEX_DIGITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_fire,
    input  wire logic [7:0]  in_byte,
    input  wire logic        in_eoi,
    output push_t            push
);

    mode_t        mode_reg, mode_next;
    pend_t        pk_reg, pk_next;
    logic [7:0]   fb_reg, fb_next;
    logic [15:0]  acc_reg, acc_next;
    logic [2:0]   dc_reg, dc_next;
    logic [127:0] buf_reg, buf_next;
    logic [4:0]   ncnt_reg, ncnt_next;
    logic [15:0]  line_reg, line_next;
    logic [1:0]   err_reg, err_next;

    res_t         ra, rb;
    logic         va, vb, do_flush, do_fresh, clr_all, is_end;
    logic [15:0]  acc_upd;
    logic [3:0]   dc_upd;
    logic [127:0] buf_upd;
    logic [4:0]   ncnt_upd;
    logic [4:0]   hv;
    kind_t        pair;
    logic [15:0]  line_inc;

    assign line_inc = (line_reg != 16'hFFFF) ? line_reg + 16'd1 : line_reg;

    always_comb begin
        mode_next = mode_reg;
        pk_next   = pk_reg;
        fb_next   = fb_reg;
        acc_next  = acc_reg;
        dc_next   = dc_reg;
        buf_next  = buf_reg;
        ncnt_next = ncnt_reg;
        line_next = line_reg;
        err_next  = err_reg;
        ra = '0;
        rb = '0;
        ra.err = err_reg;
        va = 1'b0;
        vb = 1'b0;
        do_flush = 1'b0;
        do_fresh = 1'b0;
        clr_all  = 1'b0;
        is_end   = in_eoi || in_byte == 8'd0;
        acc_upd  = '0;
        dc_upd   = '0;
        buf_upd  = buf_reg;
        ncnt_upd = ncnt_reg;
        hv       = hex_val(in_byte);
        pair     = op_pair(fb_reg, in_byte);

        if (is_end) begin
            if (mode_reg == MODE_STRING) begin
                if (pk_reg == PK_ESC) begin
                    va = 1'b1;
                    ra.kind = K_ERROR;
                    ra.err = 2'd2;
                end else if (pk_reg == PK_HEX) begin
                    va = 1'b1;
                    ra.kind = K_NUMBER;
                    ra.num = acc_reg;
                end
                err_next = 2'd1;
            end else if (mode_reg != MODE_COMMENT) begin
                do_flush = 1'b1;
            end
            vb = 1'b1;
            rb.kind = K_END;
            clr_all = 1'b1;
        end else begin
            case (mode_reg)
                MODE_STRING: begin
                    if (pk_reg == PK_ESC) begin
                        pk_next = PK_NONE;
                        vb = 1'b1;
                        rb.kind = K_CHAR;
                        rb.ch = esc_map(in_byte);
                    end else if (pk_reg == PK_HEX && hv[4]) begin
                        acc_upd = {acc_reg[11:0], hv[3:0]};
                        dc_upd  = {1'b0, dc_reg} + 4'd1;
                        acc_next = acc_upd;
                        dc_next  = dc_upd[2:0];
                        if (dc_upd >= 4'(MAX_HEX_DIGITS)) begin
                            vb = 1'b1;
                            rb.kind = K_NUMBER;
                            rb.num = acc_upd;
                            acc_next = '0;
                            dc_next = '0;
                            pk_next = PK_NONE;
                        end
                    end else begin
                        if (pk_reg == PK_HEX) begin
                            va = 1'b1;
                            ra.kind = K_NUMBER;
                            ra.num = acc_reg;
                            acc_next = '0;
                            dc_next = '0;
                        end
                        pk_next = PK_NONE;
                        case (in_byte)
                            "\"": begin
                                mode_next = MODE_NORMAL;
                                vb = 1'b1;
                                rb.kind = K_QUOTE;
                            end
                            8'd10: line_next = line_inc;
                            "\\": pk_next = PK_ESC;
                            "#": begin
                                pk_next = PK_HEX;
                                acc_next = '0;
                                dc_next = '0;
                            end
                            default: begin
                                vb = 1'b1;
                                rb.kind = K_CHAR;
                                rb.ch = in_byte;
                            end
                        endcase
                    end
                end
                MODE_COMMENT: begin
                    vb = 1'b1;
                    if (in_byte == 8'd10 || in_byte == 8'd13) begin
                        line_next = line_inc;
                        mode_next = MODE_NORMAL;
                        rb.kind = K_NEWLINE;
                    end else begin
                        rb.kind = K_CHAR;
                        rb.ch = in_byte;
                    end
                end
                default: begin
                    if (pk_reg == PK_OP && pair != K_ERROR) begin
                        pk_next = PK_NONE;
                        fb_next = '0;
                        if (pair == K_COMMENT) begin
                            mode_next = MODE_COMMENT;
                        end
                        vb = 1'b1;
                        rb.kind = pair;
                    end else if (pk_reg == PK_NUM && is_digit(in_byte)) begin
                        acc_upd = {acc_reg[12:0], 3'b000} + {acc_reg[14:0], 1'b0}
                                + {8'd0, in_byte - "0"};
                        dc_upd  = {1'b0, dc_reg} + 4'd1;
                        acc_next = acc_upd;
                        dc_next  = dc_upd[2:0];
                        if (dc_upd >= 4'(MAX_DEC_DIGITS)) begin
                            vb = 1'b1;
                            rb.kind = K_NUMBER;
                            rb.num = acc_upd;
                            acc_next = '0;
                            dc_next = '0;
                            pk_next = PK_NONE;
                        end
                    end else if (pk_reg == PK_NAME
                                 && (is_alpha(in_byte) || is_digit(in_byte))) begin
                        buf_upd[ncnt_reg[3:0]*8 +: 8] = in_byte;
                        ncnt_upd = ncnt_reg + 5'd1;
                        buf_next  = buf_upd;
                        ncnt_next = ncnt_upd;
                        if (ncnt_upd >= 5'(MAX_NAME_CHARS)) begin
                            vb = 1'b1;
                            rb.kind = kw_kind(buf_upd[63:0], ncnt_upd);
                            rb.len = ncnt_upd;
                            rb.lo = buf_upd[63:0];
                            rb.hi = buf_upd[127:64];
                            buf_next = '0;
                            ncnt_next = '0;
                            pk_next = PK_NONE;
                        end
                    end else begin
                        do_flush = 1'b1;
                        do_fresh = 1'b1;
                    end
                end
            endcase
        end

        if (do_flush) begin
            case (pk_reg)
                PK_OP: begin
                    va = 1'b1;
                    ra.kind = op_single(fb_reg);
                end
                PK_NUM: begin
                    va = 1'b1;
                    ra.kind = K_NUMBER;
                    ra.num = acc_reg;
                end
                PK_NAME: begin
                    va = 1'b1;
                    ra.kind = kw_kind(buf_reg[63:0], ncnt_reg);
                    ra.len = ncnt_reg;
                    ra.lo = buf_reg[63:0];
                    ra.hi = buf_reg[127:64];
                end
                default: ;
            endcase
            pk_next = PK_NONE;
            fb_next = '0;
            acc_next = '0;
            dc_next = '0;
            buf_next = '0;
            ncnt_next = '0;
        end

        if (do_fresh) begin
            vb = 1'b1;
            case (in_byte)
                8'd10, 8'd13: begin
                    line_next = line_inc;
                    rb.kind = K_NEWLINE;
                end
                " ", 8'd12, 8'd9, 8'd11, ";": rb.kind = K_SPACE;
                "\"": begin
                    mode_next = MODE_STRING;
                    rb.kind = K_QUOTE;
                end
                "+": rb.kind = K_PLUS;
                "*": rb.kind = K_MUL;
                "/": rb.kind = K_DIV;
                "%": rb.kind = K_MOD;
                "^": rb.kind = K_XOR;
                ",": rb.kind = K_COMMA;
                "(": rb.kind = K_LPAR;
                ")": rb.kind = K_RPAR;
                "{": rb.kind = K_LBRACE;
                "}": rb.kind = K_RBRACE;
                "[": rb.kind = K_LBRACK;
                "]": rb.kind = K_RBRACK;
                "-", "<", ">", "=", "!", "&", "|": begin
                    vb = 1'b0;
                    pk_next = PK_OP;
                    fb_next = in_byte;
                end
                default: begin
                    if (is_digit(in_byte)) begin
                        if (MAX_DEC_DIGITS <= 1) begin
                            rb.kind = K_NUMBER;
                            rb.num = {8'd0, in_byte - "0"};
                        end else begin
                            vb = 1'b0;
                            pk_next = PK_NUM;
                            acc_next = {8'd0, in_byte - "0"};
                            dc_next = 3'd1;
                        end
                    end else if (is_alpha(in_byte)) begin
                        vb = 1'b0;
                        pk_next = PK_NAME;
                        buf_next = {120'd0, in_byte};
                        ncnt_next = 5'd1;
                    end else begin
                        err_next = 2'd3;
                        rb.kind = K_ERROR;
                    end
                end
            endcase
        end

        if (clr_all) begin
            mode_next = MODE_NORMAL;
            pk_next = PK_NONE;
            fb_next = '0;
            acc_next = '0;
            dc_next = '0;
            buf_next = '0;
            ncnt_next = '0;
        end

        ra.line = line_reg;
        rb.line = line_next;
        rb.err  = err_next;
        ra.last = !vb;
        rb.last = 1'b1;

        push.cnt = in_fire ? {1'b0, va} + {1'b0, vb} : 2'd0;
        push.d0  = va ? ra : rb;
        push.d1  = rb;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NORMAL;
            pk_reg   <= PK_NONE;
            fb_reg   <= '0;
            acc_reg  <= '0;
            dc_reg   <= '0;
            buf_reg  <= '0;
            ncnt_reg <= '0;
            line_reg <= 16'd1;
            err_reg  <= '0;
        end else if (in_fire) begin
            mode_reg <= mode_next;
            pk_reg   <= pk_next;
            fb_reg   <= fb_next;
            acc_reg  <= acc_next;
            dc_reg   <= dc_next;
            buf_reg  <= buf_next;
            ncnt_reg <= ncnt_next;
            line_reg <= line_next;
            err_reg  <= err_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/stl_queue.sv
// Back end: result queue taking up to two items per cycle while it has room and presenting one.
`default_nettype none

module stl_queue import stl_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire push_t       push,
    output logic             space_ok,
    output logic             out_valid,
    input  wire logic        out_ready,
    output res_t             out_data,
    output logic [QAW:0]     count
);

    res_t             mem [QDEPTH];
    logic [QAW-1:0]   wr_reg, rd_reg;
    logic [QAW:0]     cnt_reg;
    logic             pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = cnt_reg != '0;
    assign space_ok  = cnt_reg <= (QAW+1)'(QDEPTH - 2);
    assign count     = cnt_reg;

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            mem[wr_reg] <= push.d0;
        end
        if (push.cnt == 2'd2) begin
            mem[wr_reg + QAW'(1)] <= push.d1;
        end
    end

    always_comb out_data = mem[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_reg + QAW'(push.cnt);
            rd_reg  <= rd_reg + QAW'(pop);
            cnt_reg <= cnt_reg + (QAW+1)'(push.cnt) - (QAW+1)'(pop);
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/script_token_lexer_top.sv
// Top level of the script token lexer: front end, result queue and ports.
`default_nettype none

// Takes one source byte per item and returns tokens in order, each marked
// last on the final token of its item. An item is accepted in the cycle it
// arrives whenever the four-entry result queue holds two or fewer tokens, so
// bytes stream at one per cycle while the queue has room; an item that
// makes two tokens presents them one at a time, and the queue absorbs the
// extra one until it fills. Tokens enter the queue as their byte is accepted.
// Line count and error code are sticky across end marks until reset.
module script_token_lexer_top import stl_pkg::*; #(
    parameter int MAX_NAME_CHARS = MAX_NAME_CHARS_DEF,
    parameter int MAX_DEC_DIGITS = MAX_DEC_DIGITS_DEF,
    parameter int MAX_HEX_DIGITS = MAX_HEX_DIGITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_src_byte,
    input  wire logic        s_end_of_input,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [5:0]       m_token_kind,
    output logic [7:0]       m_char_value,
    output logic [15:0]      m_number_value,
    output logic [4:0]       m_name_length,
    output logic [63:0]      m_name_bytes_low,
    output logic [63:0]      m_name_bytes_high,
    output logic [15:0]      m_line_number,
    output logic [1:0]       m_error_code,
    output logic             m_last
);

    push_t          push;
    res_t           q_out;
    logic           space_ok;
    logic [QAW:0]   q_count;

    assign s_ready = space_ok;

    stl_front #(
        .MAX_NAME_CHARS (MAX_NAME_CHARS),
        .MAX_DEC_DIGITS (MAX_DEC_DIGITS),
        .MAX_HEX_DIGITS (MAX_HEX_DIGITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (s_valid && s_ready),
        .in_byte (s_src_byte),
        .in_eoi  (s_end_of_input),
        .push    (push)
    );

    stl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .space_ok  (space_ok),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (q_out),
        .count     (q_count)
    );

    assign m_token_kind      = q_out.kind;
    assign m_char_value      = q_out.ch;
    assign m_number_value    = q_out.num;
    assign m_name_length     = q_out.len;
    assign m_name_bytes_low  = q_out.lo;
    assign m_name_bytes_high = q_out.hi;
    assign m_line_number     = q_out.line;
    assign m_error_code      = q_out.err;
    assign m_last            = q_out.last;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= (QAW+1)'(QDEPTH))
        else $error("result queue overflow");

    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_token_kind == K_END |-> m_last)
        else $error("end token not last of its item");

    a_line_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_line_number != 16'd0)
        else $error("line number zero");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push.cnt != 2'd0 |-> space_ok)
        else $error("push without room");

endmodule

`default_nettype wire
